// ----- rtl/swmf_pkg.sv -----
// Shared types and constants for the separable window median filter.
// Depends on nothing; used by all modules under rtl.
package swmf_pkg;

    localparam int MaxWidth  = 4096;
    localparam int PixelBits = 8;
    localparam int ColBits   = $clog2(MaxWidth);
    localparam int LineRows  = 4;
    localparam int RowSelBits = 2;
    localparam int QueueDepth = 4;
    localparam int QueueBits  = 2;
    localparam int CfgBits    = 16;
    localparam int RegIdxBits = 2;
    localparam int PipeStages = 6;

    localparam logic [RegIdxBits-1:0] RegRadius = 2'd0;
    localparam logic [RegIdxBits-1:0] RegWidth  = 2'd1;
    localparam logic [RegIdxBits-1:0] RegHeight = 2'd2;

    typedef logic [PixelBits-1:0] t_pix;

    // classified word handed from the front part to the back part
    typedef struct packed {
        t_pix                  pixel;
        logic [ColBits-1:0]    col;
        logic [RowSelBits-1:0] row_sel;
        logic                  big;
        logic                  emit;
        logic                  row_end;
        logic                  frame_end;
    } t_cmd;

    // compare-exchange: return {max, min}
    function automatic logic [2*PixelBits-1:0] cmp_swap(input t_pix a, input t_pix b);
        return (a > b) ? {a, b} : {b, a};
    endfunction

endpackage

// ----- rtl/swmf_front.sv -----
// Front part: position tracking and classification of each input word.
// Depends on swmf_pkg.
module swmf_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [swmf_pkg::RegIdxBits-1:0] i_cfg_idx,
    input  logic [swmf_pkg::CfgBits-1:0]    i_cfg_data,
    input  logic                    i_valid,
    input  swmf_pkg::t_pix          i_pixel,
    input  logic                    i_frame_start,
    output logic                    o_take,
    input  logic                    i_space,
    output logic                    o_push,
    output swmf_pkg::t_cmd          o_cmd
);
    logic [1:0]  r_radius;
    logic [12:0] r_width;
    logic [15:0] r_height;
    logic [11:0] r_col;
    logic [15:0] r_row;

    logic [12:0] width;
    logic [11:0] col0, n_col;
    logic [15:0] row0, n_row;
    logic        big, live;
    logic [2:0]  dm1;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 2'd1;
            r_width  <= 13'd640;
            r_height <= 16'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swmf_pkg::RegRadius: r_radius <= i_cfg_data[1:0];
                swmf_pkg::RegWidth:  r_width  <= i_cfg_data[12:0];
                swmf_pkg::RegHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_take = i_space;

    // classify the current word
    always_comb begin
        width = r_width;
        if (width == 13'd0) width = 13'd1;
        if (width > 13'(swmf_pkg::MaxWidth)) width = 13'(swmf_pkg::MaxWidth);
        big  = r_radius[1];
        dm1  = big ? 3'd4 : 3'd2;
        col0 = i_frame_start ? 12'd0 : r_col;
        row0 = i_frame_start ? 16'd0 : r_row;
        if ({1'b0, col0} >= width) col0 = 12'd0;
        live = row0 < r_height;
        o_push = i_valid && i_space && live;
        o_cmd.pixel     = i_pixel;
        o_cmd.col       = col0;
        o_cmd.row_sel   = row0[1:0];
        o_cmd.big       = big;
        o_cmd.emit      = (row0 >= 16'(dm1)) && (col0 >= 12'(dm1));
        o_cmd.row_end   = ({1'b0, col0} == width - 13'd1);
        o_cmd.frame_end = o_cmd.row_end && (row0 == r_height - 16'd1);
        if ({1'b0, col0} + 13'd1 >= width) begin
            n_col = 12'd0;
            n_row = (row0 == 16'hFFFF) ? 16'hFFFF : row0 + 16'd1;
        end else begin
            n_col = col0 + 12'd1;
            n_row = row0;
        end
    end

    // advance position on every accepted word of the frame; past its end only a frame start resets it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_valid && i_space) begin
            if (live) begin
                r_col <= n_col;
                r_row <= n_row;
            end else if (i_frame_start) begin
                r_col <= '0;
                r_row <= '0;
            end
        end
    end
endmodule

// ----- rtl/swmf_queue.sv -----
// Short FIFO of classified words between front and back.
// Depends on swmf_pkg.
module swmf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  swmf_pkg::t_cmd i_cmd,
    output logic           o_space,
    output logic           o_avail,
    input  logic           i_pop,
    output swmf_pkg::t_cmd o_cmd
);
    swmf_pkg::t_cmd r_mem [swmf_pkg::QueueDepth];
    logic [swmf_pkg::QueueBits-1:0] r_wp, r_rp;
    logic [swmf_pkg::QueueBits:0]   r_cnt;

    assign o_space = r_cnt != 3'(swmf_pkg::QueueDepth);
    assign o_avail = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

    // store pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_space || i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail) else $error("queue underflow");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 3'd1) else $error("count");
`endif
endmodule

// ----- rtl/swmf_back.sv -----
// Back part: line store, 5x5 window and median network, output register.
// Depends on swmf_pkg.
module swmf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  swmf_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output swmf_pkg::t_pix o_median,
    output logic           o_row_end,
    output logic           o_frame_end
);
    // one entry per column holds that column's pixel of all four stored rows
    logic [swmf_pkg::LineRows-1:0][swmf_pkg::PixelBits-1:0] r_line [swmf_pkg::MaxWidth];
    logic [swmf_pkg::LineRows-1:0][swmf_pkg::PixelBits-1:0] r_rdq;
    swmf_pkg::t_cmd r_c1;
    logic           r_v1;
    swmf_pkg::t_pix r_win [5][5];

    // pipeline of window snapshots
    swmf_pkg::t_pix r_w [swmf_pkg::PipeStages][25];
    logic [swmf_pkg::PipeStages-1:0] r_sv;
    logic           r_srend [swmf_pkg::PipeStages];
    logic           r_sfend [swmf_pkg::PipeStages];

    logic           r_ov;
    swmf_pkg::t_pix r_omed;
    logic           r_orend, r_ofend;

    logic adv;
    logic [swmf_pkg::PipeStages:0] cnt_in_flight;

    // pipeline stalls only when the output register holds a word and the output is blocked
    assign adv   = !(r_ov && i_stall);
    assign o_pop = i_avail && adv;

    // line store: read the whole column, write the current row's lane
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdq <= r_line[i_cmd.col];
            r_line[i_cmd.col][i_cmd.row_sel] <= i_cmd.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= o_pop;
        if (o_pop) r_c1 <= i_cmd;
    end

    // shift window one column and load the new one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 5; c++)
                for (int r = 0; r < 5; r++) r_win[c][r] <= '0;
        end else if (adv && r_v1) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 5; r++) r_win[c][r] <= r_win[c+1][r];
            for (int k = 1; k <= 4; k++)
                r_win[4][4-k] <= r_rdq[2'(r_c1.row_sel - 2'(k))];
            r_win[4][4] <= r_c1.pixel;
        end
    end

    // capture window snapshot for emitting words
    logic r_e2, r_b2, r_re2, r_fe2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e2 <= 1'b0;
        else if (adv) r_e2 <= r_v1 && r_c1.emit;
        if (adv) begin
            r_b2 <= r_c1.big; r_re2 <= r_c1.row_end; r_fe2 <= r_c1.frame_end;
        end
    end

    // stage 0: load values; 3x3 uses rows/cols 2..4, others padded with min/max
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= '0;
        else if (adv) r_sv <= {r_sv[swmf_pkg::PipeStages-2:0], r_e2};
        if (adv) begin
            for (int c = 0; c < 5; c++)
                for (int r = 0; r < 5; r++) begin
                    if (r_b2 || (c >= 2 && r >= 2)) r_w[0][c*5+r] <= r_win[c][r];
                    else r_w[0][c*5+r] <= ((c + r) % 2 == 0) ? '0 : '1;
                end
            r_srend[0] <= r_re2; r_sfend[0] <= r_fe2;
            // odd-even transposition passes, 5 per stage over stages 1..PipeStages-1
            for (int s = 1; s < swmf_pkg::PipeStages; s++) begin
                logic [swmf_pkg::PixelBits-1:0] t [25];
                logic [2*swmf_pkg::PixelBits-1:0] sw;
                for (int i = 0; i < 25; i++) t[i] = r_w[s-1][i];
                for (int p = 0; p < 5; p++)
                    for (int i = (((s-1)*5+p) % 2); i < 24; i += 2) begin
                        sw = swmf_pkg::cmp_swap(t[i], t[i+1]);
                        t[i] = sw[swmf_pkg::PixelBits-1:0];
                        t[i+1] = sw[2*swmf_pkg::PixelBits-1:swmf_pkg::PixelBits];
                    end
                for (int i = 0; i < 25; i++) r_w[s][i] <= t[i];
                r_srend[s] <= r_srend[s-1];
                r_sfend[s] <= r_sfend[s-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_sv[swmf_pkg::PipeStages-1];
        if (adv) begin
            r_omed  <= r_w[swmf_pkg::PipeStages-1][12];
            r_orend <= r_srend[swmf_pkg::PipeStages-1];
            r_ofend <= r_sfend[swmf_pkg::PipeStages-1];
        end
    end

    assign o_valid     = r_ov;
    assign o_median    = r_omed;
    assign o_row_end   = r_orend;
    assign o_frame_end = r_ofend;
    assign cnt_in_flight = (swmf_pkg::PipeStages+1)'($countones(r_sv));

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> $stable(r_omed) && r_ov) else $error("output moved");
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ofend) |-> r_orend) else $error("frame end without row end");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_in_flight <= (swmf_pkg::PipeStages+1)'(swmf_pkg::PipeStages))
        else $error("pipeline count");
`endif
endmodule

// ----- rtl/separable_window_median_filter.sv -----
// Streaming 3x3/5x5 median filter top level.
// Throughput: one pixel per cycle while i_stall does not hold the output back.
// Path: queue, line store read, window register, snapshot, 5 sort stages and the output register.
// A stalled output freezes the back pipeline; the 4-word queue then fills and raises o_stall.
// Synchronous active-low reset clears position, window and queue; line store
// contents are undefined until written. Configuration resets to 3x3, 640x480.
module separable_window_median_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_median,
    output logic        o_row_end,
    output logic        o_frame_end
);
    logic           take, push, space, avail, pop;
    swmf_pkg::t_cmd f_cmd, q_cmd;

    swmf_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_pixel, .i_frame_start,
        .o_take(take), .i_space(space), .o_push(push), .o_cmd(f_cmd)
    );

    swmf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(f_cmd), .o_space(space),
        .o_avail(avail), .i_pop(pop), .o_cmd(q_cmd)
    );

    swmf_back u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_cmd(q_cmd), .o_pop(pop),
        .o_valid, .i_stall, .o_median, .o_row_end, .o_frame_end
    );

    assign o_stall = !take;
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the 3x3/5x5 streaming median filter.
// Depends on rtl/swmf_pkg.sv and rtl/separable_window_median_filter.sv.
// Drives raster frames under random handshake gaps and checks each word against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit  = 3000;
    localparam int HoldCycles = 300;
    localparam int DrainWait  = 30;

    typedef struct {
        swmf_pkg::t_pix med;
        bit   row_end;
        bit   frame_end;
    } t_median_word;

    typedef struct packed {
        logic [7:0] px;
        logic       fs;
        logic       known;
        logic [7:0] med;
    } t_dir_row;

    // 5x5 frame at 3x3: three bright rows over two dark rows
    localparam t_dir_row DirFrame [25] = '{
        '{8'hFF, 1'b1, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
        '{8'hFF, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'hFF},
        '{8'h00, 1'b0, 1'b1, 8'hFF}, '{8'h00, 1'b0, 1'b1, 8'hFF},
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'h00, 1'b0, 1'b1, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'h00}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [swmf_pkg::RegIdxBits-1:0] i_cfg_idx;
    logic [swmf_pkg::CfgBits-1:0]    i_cfg_data;
    logic                            i_valid;
    logic                            o_stall;
    swmf_pkg::t_pix                  i_pixel;
    logic                            i_frame_start;
    logic                            o_valid;
    logic                            i_stall;
    swmf_pkg::t_pix                  o_median;
    logic                            o_row_end;
    logic                            o_frame_end;

    // predictor state
    swmf_pkg::t_pix line_rows [swmf_pkg::LineRows][swmf_pkg::MaxWidth];
    swmf_pkg::t_pix win [5][5];
    int          pos_col;
    int          pos_row;
    logic [1:0]  cfg_radius;
    logic [12:0] cfg_width;
    logic [15:0] cfg_height;

    t_median_word pending_medians [$];
    int  mismatches;
    int  idle_cycles;
    int  burst_left;
    int  sent_words;
    bit  hold_request;

    separable_window_median_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_median     (o_median),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > swmf_pkg::MaxWidth) w = swmf_pkg::MaxWidth;
        return w;
    endfunction

    function automatic int eff_radius();
        return cfg_radius[1] ? 2 : 1;
    endfunction

    // advance the window by one pixel and work out the median it yields, if any
    task automatic predict_median(input swmf_pkg::t_pix px, input bit fs, output bit hit,
                                  output t_median_word res);
        int   width;
        int   diam;
        int   col;
        int   row;
        int   n;
        int   j;
        swmf_pkg::t_pix sorted [25];
        swmf_pkg::t_pix x;
        hit = 1'b0;
        res = '{default: 0};
        width = eff_width();
        diam = 2 * eff_radius() + 1;
        if (fs) begin
            pos_col = 0;
            pos_row = 0;
        end
        if (pos_row >= cfg_height) return;
        if (pos_col >= width) pos_col = 0;
        col = pos_col;
        row = pos_row;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 5; r++) win[c][r] = win[c + 1][r];
        for (int k = 1; k <= 4; k++) win[4][4 - k] = line_rows[(row - k) & 3][col];
        win[4][4] = px;
        line_rows[row & 3][col] = px;
        if (row >= diam - 1 && col >= diam - 1) begin
            n = 0;
            // insertion sort of the active window
            for (int c = 5 - diam; c < 5; c++) begin
                for (int r = 5 - diam; r < 5; r++) begin
                    x = win[c][r];
                    j = n;
                    while (j > 0 && sorted[j - 1] > x) begin
                        sorted[j] = sorted[j - 1];
                        j--;
                    end
                    sorted[j] = x;
                    n++;
                end
            end
            res.med = sorted[n / 2];
            res.row_end = (col == width - 1);
            res.frame_end = (col == width - 1) && (row == cfg_height - 1);
            hit = 1'b1;
        end
        if (col + 1 >= width) begin
            pos_col = 0;
            pos_row = (row + 1 > 16'hFFFF) ? 16'hFFFF : row + 1;
        end else begin
            pos_col = col + 1;
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // offer one word in bursts, wait for acceptance, then predict
    task automatic send_word(input swmf_pkg::t_pix px, input bit fs, input bit known,
                             input swmf_pkg::t_pix med);
        bit           hit;
        t_median_word res;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 10);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_stall);
        sent_words++;
        predict_median(px, fs, hit, res);
        if (known) res.med = med;
        if (hit) pending_medians.insert(pending_medians.size(), res);
    endtask

    // write one register; only called with the block idle, enable dropped by the caller
    task automatic write_reg(input logic [swmf_pkg::RegIdxBits-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[swmf_pkg::CfgBits-1:0];
        @(posedge i_clk);
        if (idx == swmf_pkg::RegRadius) cfg_radius = value[1:0];
        else if (idx == swmf_pkg::RegWidth) cfg_width = value[12:0];
        else if (idx == swmf_pkg::RegHeight) cfg_height = value[15:0];
    endtask

    task automatic configure(input int radius, input int width, input int height);
        i_valid <= 1'b0;
        burst_left = 0;
        wait (pending_medians.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
        write_reg(swmf_pkg::RegRadius, radius);
        write_reg(swmf_pkg::RegWidth, width);
        write_reg(swmf_pkg::RegHeight, height);
        i_cfg_we <= 1'b0;
    endtask

    function automatic swmf_pkg::t_pix rand_pix();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return swmf_pkg::t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    // well-formed frame, or a broken one: cut short, restarted by a stray frame start, or trailed by ignored words
    task automatic send_frame(input int words);
        int len;
        int kind;
        kind = $urandom_range(0, 9);
        len = (kind == 0) ? $urandom_range(1, words) : words;
        for (int i = 0; i < len; i++)
            send_word(rand_pix(), i == 0 || (kind == 1 && $urandom_range(0, 40) == 0),
                      1'b0, 8'h00);
        if (kind == 2)
            repeat ($urandom_range(1, 6)) send_word(rand_pix(), 1'b0, 1'b0, 8'h00);
    endtask

    // check each accepted median word against the oldest expectation
    always @(posedge i_clk) begin
        t_median_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_medians.size() == 0) begin
                report("unexpected word, median", o_median, -1);
            end else begin
                want = pending_medians.pop_front();
                if (o_median !== want.med) report("median", o_median, want.med);
                if (o_row_end !== want.row_end) report("row_end", o_row_end, want.row_end);
                if (o_frame_end !== want.frame_end)
                    report("frame_end", o_frame_end, want.frame_end);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold on request
    initial begin
        int mode;
        int phase;
        mode = 0;
        phase = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                hold_request = 1'b0;
            end
            phase++;
            if (phase % 64 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                default: i_stall <= (phase % 3 == 0);
            endcase
        end
    end

    initial begin
        int r;
        int w;
        int h;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = swmf_pkg::RegRadius;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_pixel       = '0;
        i_frame_start = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        sent_words    = 0;
        hold_request  = 1'b0;
        pos_col       = 0;
        pos_row       = 0;
        cfg_radius    = 2'd1;
        cfg_width     = 13'd640;
        cfg_height    = 16'd480;
        for (int c = 0; c < 5; c++)
            for (int rr = 0; rr < 5; rr++) win[c][rr] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame, bright/dark boundary
        configure(1, 5, 5);
        foreach (DirFrame[i]) send_word(DirFrame[i].px, DirFrame[i].fs,
                                        DirFrame[i].known, DirFrame[i].med);

        // radius codes 0 and 3, and a long hold that backs up the input
        configure(0, 6, 6);
        hold_request = 1'b1;
        repeat (2) send_frame(36);
        configure(3, 9, 7);
        send_frame(63);

        // widths too narrow for any median
        configure(1, 0, 5);
        repeat (12) send_word(rand_pix(), 1'b0, 1'b0, 8'h00);
        configure(2, 4, 6);
        send_frame(24);

        // zero height: every word ignored
        configure(1, 5, 0);
        send_word(rand_pix(), 1'b1, 1'b0, 8'h00);
        repeat (6) send_word(rand_pix(), 1'b0, 1'b0, 8'h00);

        // widest row (saturated width), tallest height: the first words of each frame only
        configure(2, 16'hFFFF, 3);
        send_frame(40);
        configure(1, 13'h1000, 16'hFFFF);
        send_frame(40);
        configure(2, 6, 16'hFFFF);
        send_frame(48);

        // random settings, small frames
        while (sent_words < 450) begin
            r = $urandom_range(0, 3);
            w = $urandom_range(5, 12);
            h = $urandom_range(5, 8);
            configure(r, w, h);
            repeat ($urandom_range(1, 2)) send_frame(w * h);
        end

        i_valid <= 1'b0;
        wait (pending_medians.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/swmf_pkg.sv
rtl/swmf_front.sv
rtl/swmf_queue.sv
rtl/swmf_back.sv
rtl/separable_window_median_filter.sv
dv/tb.sv
